// File: sv/wcrc_pkg.sv
// Shared types, constants and CRC matrix for the word-wide CRC-32 block.
package wcrc_pkg;

    localparam logic [31:0] CRC_POLY   = 32'h04C1_1DB7;
    localparam logic [31:0] INIT_RESET = 32'hAAAA_AAAA;
    localparam logic [7:0]  PAD_RESET  = 8'hFF;

    localparam int unsigned ADDR_W = 3;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_INIT = 1'b0,
        REG_PAD  = 1'b1
    } reg_idx_t;

    // Configuration handed from the register file to the datapath
    typedef struct packed
    {
        logic [31:0] init_value;
        logic [7:0]  pad_byte;
    } cfg_t;

    // Row i holds the input bits that XOR into CRC bit i
    typedef logic [31:0][31:0] crc_mat_t;

    // Build the 32-shift MSB-first CRC as a GF(2) matrix (elaboration only)
    function automatic crc_mat_t crc_matrix();
        crc_mat_t    m;
        logic [31:0] v;
        m = '0;
        for (int j = 0; j < 32; j++)
        begin
            v = 32'h1 << j;
            for (int s = 0; s < 32; s++)
            begin
                if (v[31])
                    v = (v << 1) ^ CRC_POLY;
                else
                    v = v << 1;
            end
            for (int i = 0; i < 32; i++)
                m[i][j] = v[i];
        end
        return m;
    endfunction

    localparam crc_mat_t CRC_MAT = crc_matrix();

    // Clock one word through the CRC register: one XOR tree per output bit
    function automatic logic [31:0] crc_absorb(input logic [31:0] x);
        logic [31:0] r;
        for (int i = 0; i < 32; i++)
            r[i] = ^(x & CRC_MAT[i]);
        return r;
    endfunction

endpackage

// File: sv/wcrc_cfg.sv
// APB-style register file holding the initial value and the pad byte.
module wcrc_cfg
    import wcrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [31:0] init_reg;
    logic [7:0]  pad_reg;
    logic        wr_en;
    reg_idx_t    idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[2]);

    // Update the addressed register on a completed write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= INIT_RESET;
            pad_reg  <= PAD_RESET;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_INIT: init_reg <= pwdata;
                REG_PAD:  pad_reg  <= pwdata[7:0];
                default:  ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (idx)
            REG_INIT: prdata = init_reg;
            REG_PAD:  prdata = {24'h0, pad_reg};
            default:  prdata = '0;
        endcase
    end

    assign cfg.init_value = init_reg;
    assign cfg.pad_byte   = pad_reg;

endmodule

// File: sv/wcrc_pipe.sv
// Two-register datapath: input register, lane padding and CRC, result register.
module wcrc_pipe
    import wcrc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] data_word,
    input  logic [2:0]  valid_bytes,
    input  logic        first_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] crc_value
);

    logic        s1_valid_reg;
    logic [31:0] s1_data_reg;
    logic [2:0]  s1_count_reg;
    logic        s1_first_reg;
    logic        out_valid_reg;
    logic [31:0] out_crc_reg;
    logic [31:0] crc_running_reg;
    logic [31:0] crc_running_next;
    logic        out_free;
    logic        s1_adv;
    logic        in_take;
    logic [31:0] padded;
    logic [31:0] crc_base;

    // Handshake: the result register frees when empty or being taken
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Replace lanes at or above the valid count with the pad byte
    always_comb
    begin
        for (int lane = 0; lane < 4; lane++)
        begin
            if (s1_count_reg > 3'(lane))
                padded[8*lane +: 8] = s1_data_reg[8*lane +: 8];
            else
                padded[8*lane +: 8] = cfg.pad_byte;
        end
    end

    // Reload on a first word, then absorb the padded word
    assign crc_base         = s1_first_reg ? cfg.init_value : crc_running_reg;
    assign crc_running_next = crc_absorb(crc_base ^ padded);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            crc_running_reg <= INIT_RESET;
        end
        else
        begin
            if (in_take)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;

            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            if (s1_adv)
                crc_running_reg <= crc_running_next;
        end
    end

    // Payload registers: capture input, hold result while stalled
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_data_reg  <= data_word;
            s1_count_reg <= valid_bytes;
            s1_first_reg <= first_word;
        end
        if (s1_adv)
            out_crc_reg <= crc_running_next;
    end

    assign out_valid = out_valid_reg;
    assign crc_value = out_crc_reg;

endmodule

// File: sv/word_crc32_with_pad_top.sv
// Top level of the word-wide CRC-32 block with pad-byte lane filling.
//
// Usage:
//   Input channel (in_valid/in_stall) carries data_word (first byte in bits
//   7..0), valid_bytes (0..4, larger counts act as 4) and first_word. Lanes at
//   or above valid_bytes take the pad byte. first_word reloads the initial
//   value before the word is absorbed.
//   Output channel (out_valid/out_stall) returns crc_value, the running
//   CRC-32 (poly 04C11DB7, MSB first, no final XOR) after each word.
//   Config port (APB): 0x0 init value, 0x4 pad byte; write only while idle.
// Timing:
//   Each word is held in the input register, then passes through the CRC logic
//   feeding the result register. Throughput is one word per cycle while out_stall
//   is low, set by the combinational XOR matrix that folds a whole word into the CRC register.
// Reset:
//   Init value 0xAAAAAAAA, pad byte 0xFF, running CRC 0xAAAAAAAA, both
//   pipeline registers empty.
// Stall:
//   A stalled result holds in place; the input register holds one more
//   transaction, after which in_stall rises until the result is taken.
module word_crc32_with_pad_top
    import wcrc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [31:0]       data_word,
    input  logic [2:0]        valid_bytes,
    input  logic              first_word,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [31:0]       crc_value
);

    cfg_t cfg;

    wcrc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    wcrc_pipe u_pipe
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .first_word  (first_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .crc_value   (crc_value)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the word-wide CRC-32 block with pad-byte lane filling.
module tb;
    import wcrc_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int PHASES         = 9;
    localparam int PHASE_WORDS    = 148;

    // Running CRC predictor plus the queue of CRC values still owed by the block
    class crc_scoreboard;
        logic [31:0] init_val;
        logic [7:0]  pad_val;
        logic [31:0] crc_run;
        logic [31:0] crc_owed[$];
        int          mismatches;
        int          words;
        int          messages;
        int          checked;

        function new();
            init_val   = INIT_RESET;
            pad_val    = PAD_RESET;
            crc_run    = INIT_RESET;
            mismatches = 0;
            words      = 0;
            messages   = 0;
            checked    = 0;
        endfunction

        // Shift one word through the register, MSB first
        function logic [31:0] fold_word(logic [31:0] crc, logic [31:0] w);
            logic [31:0] r;
            r = crc ^ w;
            for (int b = 0; b < 32; b++)
            begin
                if (r[31])
                    r = (r << 1) ^ CRC_POLY;
                else
                    r = r << 1;
            end
            return r;
        endfunction

        // Note an accepted input transaction and predict its CRC
        function void note_word(logic [31:0] d, logic [2:0] n, logic f);
            logic [31:0] w;
            int          lanes;
            lanes = (n > 3'd4) ? 4 : int'(n);
            for (int lane = 0; lane < 4; lane++)
                w[8*lane +: 8] = (lane < lanes) ? d[8*lane +: 8] : pad_val;
            if (f)
            begin
                crc_run = init_val;
                messages++;
            end
            crc_run = fold_word(crc_run, w);
            crc_owed.push_back(crc_run);
            words++;
        endfunction

        // Compare an accepted result transaction with the oldest prediction
        function void check_crc(logic [31:0] got);
            logic [31:0] want;
            checked++;
            if (crc_owed.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected crc_value %08h with nothing pending", got);
                return;
            end
            want = crc_owed.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: crc_value expected %08h actual %08h", want, got);
            end
        endfunction

        function int pending();
            return crc_owed.size();
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              in_valid;
    logic              in_stall;
    logic [31:0]       data_word;
    logic [2:0]        valid_bytes;
    logic              first_word;
    logic              out_valid;
    logic              out_stall;
    logic [31:0]       crc_value;

    crc_scoreboard sb;
    bit            calm;
    int            quiet_cycles;
    int            settings_used;

    word_crc32_with_pad_top dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_word   (data_word),
        .valid_bytes (valid_bytes),
        .first_word  (first_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .crc_value   (crc_value)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watch both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_word(data_word, valid_bytes, first_word);
            if (out_valid && !out_stall)
                sb.check_crc(crc_value);
        end
    end

    // Count cycles in which neither channel moves a transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Abort a hung run
    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("watchdog expired with %0d results outstanding", sb.pending());
        $display("FAILURE");
        $finish;
    end

    // Stall the result channel in random bursts, with quiet stretches
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm)
            begin
                case ($urandom_range(0, 15))
                    0:
                    begin
                        out_stall <= 1'b1;
                        repeat ($urandom_range(1, 16)) @(negedge clk);
                        out_stall <= 1'b0;
                    end
                    1:
                        repeat ($urandom_range(20, 80)) @(negedge clk);
                    default:
                        ;
                endcase
            end
        end
    end

    // Hold one input transaction until it is taken
    task automatic send_word(input logic [31:0] d, input logic [2:0] n, input logic f);
        if (!calm && $urandom_range(0, 11) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        data_word   <= d;
        valid_bytes <= n;
        first_word  <= f;
        in_valid    <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Drop valid and wait until every predicted CRC has come back
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // APB write: setup cycle, access cycle, then idle
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_INIT)
            sb.init_val = value;
        else
            sb.pad_val = value[7:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // Drain, then load a new register setting
    task automatic reconfigure(input logic [31:0] init_v, input logic [7:0] pad_v);
        drain();
        write_reg(REG_INIT, init_v);
        write_reg(REG_PAD, {24'h0, pad_v});
        settings_used++;
    endtask

    // Main stimulus
    initial
    begin
        int          left;
        logic [31:0] d;
        logic [2:0]  n;
        logic        f;

        sb            = new();
        calm          = 1'b0;
        quiet_cycles  = 0;
        settings_used = 1;
        rst_n         = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_valid      = 1'b0;
        data_word     = '0;
        valid_bytes   = '0;
        first_word    = 1'b0;

        // Hold reset, then release it
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: absorb from the reset value with no start flag
        send_word(32'h1234_5678, 3'd4, 1'b0);
        send_word(32'h0000_0000, 3'd4, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd4, 1'b0);
        // every valid count, including the saturating ones and all-pad
        for (int k = 0; k < 8; k++)
            send_word(32'hA5C3_3CA5, 3'(k), 1'b0);
        send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
        send_word(32'h0000_0000, 3'd7, 1'b1);

        // Directed: a new init value only applies at the next start flag
        drain();
        write_reg(REG_INIT, 32'h0000_0000);
        send_word(32'hDEAD_BEEF, 3'd4, 1'b0);
        send_word(32'hDEAD_BEEF, 3'd4, 1'b1);
        drain();
        write_reg(REG_PAD, 32'h0000_0000);
        settings_used++;
        send_word(32'hFFFF_FFFF, 3'd0, 1'b1);
        send_word(32'hFFFF_FFFF, 3'd1, 1'b0);
        send_word(32'hFFFF_FFFF, 3'd3, 1'b0);
        reconfigure(32'hFFFF_FFFF, 8'hFF);
        send_word(32'h0000_0000, 3'd2, 1'b1);
        send_word(32'h8000_0001, 3'd5, 1'b0);

        // Random phases of framed messages with some malformed traffic
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       reconfigure(32'h0000_0000, 8'h00);
                1:       reconfigure(32'hFFFF_FFFF, 8'hFF);
                2:       reconfigure(INIT_RESET, PAD_RESET);
                default: reconfigure($urandom, 8'($urandom_range(0, 255)));
            endcase
            if (p == PHASES - 1)
                calm = 1'b1;
            left = 0;
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                // pause once mid-phase until the block is empty
                if (p == 3 && i == PHASE_WORDS / 2)
                    drain();
                if (left == 0)
                begin
                    left = $urandom_range(1, 24);
                    f    = 1'b1;
                end
                else
                    f = 1'b0;
                left--;
                d = $urandom;
                n = (left == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
                if ($urandom_range(0, 7) == 0)
                begin
                    n = 3'($urandom_range(0, 7));
                    f = 1'($urandom_range(0, 1));
                end
                send_word(d, n, f);
            end
        end

        // Wait for the tail, then report
        drain();
        repeat (8) @(posedge clk);
        $display("Run covered %0d words in %0d messages over %0d register settings.",
                 sb.words, sb.messages, settings_used);
        $display("%0d CRC results checked, %0d mismatches.", sb.checked, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
sv/wcrc_pkg.sv
sv/wcrc_cfg.sv
sv/wcrc_pipe.sv
sv/word_crc32_with_pad_top.sv
tb/tb.sv
